[sv/sarc_pkg.sv]
// ----------------------------------------------------------------------------
// sarc_pkg
// Types and codes shared by the stepper approach/retreat controller.
// ----------------------------------------------------------------------------
package sarc_pkg;

  localparam int CountW = 13;
  localparam int FbW    = 32;
  localparam int CfgW   = 32;
  localparam int IdxW   = 1;

  // operation kinds
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // commands
  localparam logic [1:0] CMD_STOP     = 2'd0;
  localparam logic [1:0] CMD_RETREAT  = 2'd1;
  localparam logic [1:0] CMD_APPROACH = 2'd2;
  localparam logic [1:0] CMD_AUTO     = 2'd3;

  // run end status
  localparam logic [2:0] ST_NONE        = 3'd0;
  localparam logic [2:0] ST_APPROACH_OK = 3'd1;
  localparam logic [2:0] ST_RETREAT_OK  = 3'd2;
  localparam logic [2:0] ST_CANCELLED   = 3'd3;
  localparam logic [2:0] ST_MAX_STEPS   = 3'd4;

  // step direction
  localparam logic DIR_RETREAT  = 1'b0;
  localparam logic DIR_APPROACH = 1'b1;

  // configuration register indexes
  localparam logic [IdxW-1:0] REG_STOP_THRESHOLD = 1'd0;
  localparam logic [IdxW-1:0] REG_STEP_LIMIT     = 1'd1;

  localparam logic signed [FbW-1:0] THRESHOLD_RESET = 32'sd30000;
  localparam logic [CountW-1:0]     LIMIT_RESET     = 13'd5000;

  typedef struct packed {
    logic                  op;
    logic [1:0]            command;
    logic [CountW-1:0]     step_count;
    logic signed [FbW-1:0] feedback;
  } in_t;

  typedef struct packed {
    logic       step_pulse;
    logic       step_direction;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic signed [FbW-1:0] stop_threshold;
    logic [CountW-1:0]     step_limit;
  } cfg_t;

endpackage

[sv/sarc_cfg.sv]
// ----------------------------------------------------------------------------
// sarc_cfg
// Configuration register file: stop threshold and step limit.
// ----------------------------------------------------------------------------
module sarc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [sarc_pkg::IdxW-1:0]    cfg_index,
  input  logic [sarc_pkg::CfgW-1:0]    cfg_data,
  output sarc_pkg::cfg_t               cfg
);
  import sarc_pkg::*;

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_STOP_THRESHOLD: cfg_next.stop_threshold = $signed(cfg_data[FbW-1:0]);
        REG_STEP_LIMIT:     cfg_next.step_limit     = cfg_data[CountW-1:0];
        default:            cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_threshold <= THRESHOLD_RESET;
      cfg.step_limit     <= LIMIT_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

[sv/sarc_core.sv]
// ----------------------------------------------------------------------------
// sarc_core
// Run state and per-beat decision: start, step, finish or cancel a run.
// ----------------------------------------------------------------------------
module sarc_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  sarc_pkg::in_t  item,
  input  sarc_pkg::cfg_t cfg,
  output sarc_pkg::out_t res
);
  import sarc_pkg::*;

  logic              running, running_next;
  logic [1:0]        run_mode, run_mode_next;
  logic [CountW-1:0] steps_left, steps_left_next;
  logic [CountW-1:0] sat_count;
  logic              above;

  assign sat_count = (item.step_count > cfg.step_limit) ? cfg.step_limit : item.step_count;
  assign above     = item.feedback > cfg.stop_threshold;

  always_comb begin
    running_next    = running;
    run_mode_next   = run_mode;
    steps_left_next = steps_left;
    res             = '0;
    if (item.op == OP_COMMAND) begin
      if (running) begin
        if (item.command == CMD_STOP) begin
          running_next = 1'b0;
          res.done_res = 1'b1;
          res.status   = ST_CANCELLED;
        end
      end else if (item.command != CMD_STOP) begin
        running_next    = 1'b1;
        run_mode_next   = item.command;
        steps_left_next = sat_count;
      end
    end else if (running) begin
      res.step_pulse     = 1'b1;
      res.step_direction = (run_mode == CMD_RETREAT) ? DIR_RETREAT : DIR_APPROACH;
      priority if (run_mode == CMD_AUTO && above) begin
        running_next = 1'b0;
        res.done_res = 1'b1;
        res.status   = ST_APPROACH_OK;
      end else if (steps_left == '0) begin
        running_next = 1'b0;
        res.done_res = 1'b1;
        unique case (run_mode)
          CMD_RETREAT:  res.status = ST_RETREAT_OK;
          CMD_APPROACH: res.status = ST_APPROACH_OK;
          default:      res.status = ST_MAX_STEPS;
        endcase
      end else begin
        steps_left_next = steps_left - 1'b1;
      end
    end
    res.busy_res = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      run_mode   <= CMD_STOP;
      steps_left <= '0;
    end else if (fire) begin
      running    <= running_next;
      run_mode   <= run_mode_next;
      steps_left <= steps_left_next;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> !res.busy_res) else $error("done with run still busy");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    (res.status != ST_NONE) == res.done_res) else $error("status without done");

  a_pulse_running: assert property (@(posedge clk) disable iff (rst)
    res.step_pulse |-> running) else $error("pulse while idle");

  a_countdown: assert property (@(posedge clk) disable iff (rst)
    fire && running && item.op == OP_TICK && !res.done_res
    |=> steps_left == $past(steps_left) - 1'b1) else $error("step count slip");

  a_start_sat: assert property (@(posedge clk) disable iff (rst)
    fire && !running && item.op == OP_COMMAND && item.command != CMD_STOP
    |=> running && steps_left <= $past(cfg.step_limit)) else $error("limit not applied");
`endif

endmodule

[sv/stepper_approach_retreat_controller.sv]
// ----------------------------------------------------------------------------
// stepper_approach_retreat_controller
// Coarse stepper controller for tip approach and retreat.
//
// Takes one beat per clock while the output is not stalled and returns one
// result beat per input beat. The result passes through the input register,
// then the result register, before it is on the output. The run state is
// updated as the result register is loaded, so a tick or command may follow
// directly behind another. Stall on the output holds both stages and is passed
// straight back to in_stall. Configuration writes take effect on the next clock
// and belong to idle periods.
// ----------------------------------------------------------------------------
module stepper_approach_retreat_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sarc_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sarc_pkg::out_t            out_data,
  input  logic                      cfg_write,
  input  logic [sarc_pkg::IdxW-1:0] cfg_index,
  input  logic [sarc_pkg::CfgW-1:0] cfg_data
);
  import sarc_pkg::*;

  cfg_t cfg;
  in_t  item;
  logic item_valid;
  out_t res;
  logic out_ready;
  logic fire;

  assign out_ready = !out_valid || !out_stall;
  assign fire      = item_valid && out_ready;
  assign in_stall  = item_valid && !out_ready;

  sarc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sarc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

endmodule
